/* sv/nmea_sentence_framer_checker_assert.svh */
// assertion macros shared by the nmea sentence framer modules
// depends on clk and rst_n being visible in the including module
`ifndef NMEA_SENTENCE_FRAMER_CHECKER_ASSERT_SVH
`define NMEA_SENTENCE_FRAMER_CHECKER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define NSFC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define NSFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/nsfc_pkg.sv */
// shared types, character codes and helper functions for the nmea sentence framer
// no dependencies
package nsfc_pkg;

    // character codes
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_STAR   = 8'h2A;

    // sentence type strings, first letter in the top byte
    localparam logic [23:0] STR_GGA = "GGA";
    localparam logic [23:0] STR_RMC = "RMC";
    localparam logic [23:0] STR_GSV = "GSV";
    localparam logic [23:0] STR_GLL = "GLL";
    localparam logic [23:0] STR_GSA = "GSA";
    localparam logic [23:0] STR_VTG = "VTG";

    // sentence type codes
    typedef logic [2:0] nsfc_type_t;
    localparam nsfc_type_t TYPE_OTHER = 3'd0;
    localparam nsfc_type_t TYPE_GGA   = 3'd1;
    localparam nsfc_type_t TYPE_RMC   = 3'd2;
    localparam nsfc_type_t TYPE_GSV   = 3'd3;
    localparam nsfc_type_t TYPE_GLL   = 3'd4;
    localparam nsfc_type_t TYPE_GSA   = 3'd5;
    localparam nsfc_type_t TYPE_VTG   = 3'd6;

    // byte class decided by the front end
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_CR     = 2'd1,
        KIND_LF     = 2'd2,
        KIND_DOLLAR = 2'd3
    } nsfc_kind_t;

    // one queued byte with its class
    typedef struct packed {
        nsfc_kind_t kind;
        logic [7:0] data;
    } nsfc_item_t;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // upper-case hex character of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'h0, nib};
        return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
    endfunction

    // sentence type from the three letters after the talker id
    function automatic nsfc_type_t classify(input logic [23:0] letters);
        nsfc_type_t code;
        priority if (letters == STR_GGA) code = TYPE_GGA;
        else if (letters == STR_RMC) code = TYPE_RMC;
        else if (letters == STR_GSV) code = TYPE_GSV;
        else if (letters == STR_GLL) code = TYPE_GLL;
        else if (letters == STR_GSA) code = TYPE_GSA;
        else if (letters == STR_VTG) code = TYPE_VTG;
        else code = TYPE_OTHER;
        return code;
    endfunction

endpackage

/* sv/nsfc_front.sv */
// front end: takes received bytes and classifies them for the queue
// depends on nsfc_pkg
module nsfc_front (
    input  logic              in_valid,
    input  logic [7:0]        rx_byte,
    input  logic              queue_full,
    output logic              in_stall,
    output logic              push,
    output nsfc_pkg::nsfc_item_t push_item
);
    import nsfc_pkg::*;

    // accept whenever the queue has room
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // byte classification
    always_comb
    begin
        push_item.data = rx_byte;
        priority if (rx_byte == CH_DOLLAR) push_item.kind = KIND_DOLLAR;
        else if (rx_byte == CH_LF) push_item.kind = KIND_LF;
        else if (rx_byte == CH_CR) push_item.kind = KIND_CR;
        else push_item.kind = KIND_DATA;
    end

endmodule

/* sv/nsfc_queue.sv */
// two-entry queue of classified bytes between front and back
// depends on nsfc_pkg and the assertion macro header
`include "nmea_sentence_framer_checker_assert.svh"

module nsfc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  nsfc_pkg::nsfc_item_t push_item,
    input  logic              pop,
    output logic              pop_valid,
    output nsfc_pkg::nsfc_item_t pop_item,
    output logic              full
);
    import nsfc_pkg::*;

    nsfc_item_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `NSFC_ASSERT_SAME(a_pop_not_empty, pop, count_reg != '0, "pop from empty queue")
    `NSFC_ASSERT_SAME(a_push_not_full, push, !full, "push into full queue")
    `NSFC_ASSERT_NEXT(a_count_grows, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue count did not grow on push")

endmodule

/* sv/nsfc_back.sv */
// back end: line framing, running xor, tail check and result register
// depends on nsfc_pkg and the assertion macro header
`include "nmea_sentence_framer_checker_assert.svh"

module nsfc_back #(
    parameter int LINE_BYTES = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  nsfc_pkg::nsfc_item_t item,
    output logic              item_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              checksum_ok,
    output nsfc_pkg::nsfc_type_t sentence_type,
    output logic [6:0]        line_length,
    output logic [7:0]        computed_xor
);
    import nsfc_pkg::*;

    localparam int FILL_W = $clog2(LINE_BYTES);
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(LINE_BYTES - 2);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [7:0]        xor_reg, xor_next;
    logic [7:0]        tail_reg [3];
    logic [7:0]        tail_next [3];
    logic [7:0]        letters_reg [3];
    logic [7:0]        letters_next [3];
    logic [FILL_W-1:0] pos_inc;
    logic [8:0]        count_wide;
    logic              result_load;
    logic              ok_next;
    nsfc_type_t        type_next;

    logic              out_valid_reg, out_valid_next;
    logic              checksum_ok_reg;
    nsfc_type_t        sentence_type_reg;
    logic [6:0]        line_length_reg;
    logic [7:0]        computed_xor_reg;

    // only a line feed waits for room in the result register
    assign item_pop   = item_valid
                     && (item.kind != KIND_LF || !out_valid_reg || !out_stall);
    assign pos_inc    = fill_reg + 1'b1;
    assign count_wide = 9'(pos_inc);

    // line state update
    always_comb
    begin
        fill_next    = fill_reg;
        xor_next     = xor_reg;
        tail_next    = tail_reg;
        letters_next = letters_reg;
        result_load  = 1'b0;
        if (item_pop)
        begin
            priority if (item.kind == KIND_DOLLAR)
            begin
                fill_next    = FILL_W'(1);
                xor_next     = '0;
                tail_next    = '{default: 8'h00};
                letters_next = '{default: 8'h00};
            end
            else if (fill_reg >= FILL_LIMIT)
            begin
                fill_next = '0;
            end
            else if (fill_reg != '0 && item.kind != KIND_CR)
            begin
                fill_next = pos_inc;
                if (fill_reg == FILL_W'(3)) letters_next[0] = item.data;
                if (fill_reg == FILL_W'(4)) letters_next[1] = item.data;
                if (fill_reg == FILL_W'(5)) letters_next[2] = item.data;
                if (item.kind != KIND_LF)
                begin
                    if (fill_reg >= FILL_W'(4))
                    begin
                        xor_next = xor_reg ^ tail_reg[0];
                    end
                    tail_next[0] = tail_reg[1];
                    tail_next[1] = tail_reg[2];
                    tail_next[2] = item.data;
                end
                else
                begin
                    result_load = 1'b1;
                    fill_next   = '0;
                end
            end
        end
    end

    // checksum field compare and sentence type
    assign ok_next = (count_wide >= 9'd5)
                  && (tail_reg[0] == CH_STAR)
                  && (tail_reg[1] == hex_digit(xor_reg[7:4]))
                  && (tail_reg[2] == hex_digit(xor_reg[3:0]));
    assign type_next = classify({letters_next[0], letters_next[1], letters_next[2]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg    <= '0;
            xor_reg     <= '0;
            tail_reg    <= '{default: 8'h00};
            letters_reg <= '{default: 8'h00};
        end
        else
        begin
            fill_reg    <= fill_next;
            xor_reg     <= xor_next;
            tail_reg    <= tail_next;
            letters_reg <= letters_next;
        end
    end

    // result register, holds while stalled
    assign out_valid_next = result_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            checksum_ok_reg   <= ok_next;
            sentence_type_reg <= type_next;
            line_length_reg   <= count_wide[6:0];
            computed_xor_reg  <= xor_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign checksum_ok   = checksum_ok_reg;
    assign sentence_type = sentence_type_reg;
    assign line_length   = line_length_reg;
    assign computed_xor  = computed_xor_reg;

    `NSFC_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= FILL_LIMIT, "line fill beyond limit")
    `NSFC_ASSERT_SAME(a_result_on_lf, result_load, item.kind == KIND_LF && item_pop,
        "result without line feed transfer")
    `NSFC_ASSERT_NEXT(a_line_closed, result_load, fill_reg == '0 && out_valid_reg,
        "line not closed after result")

endmodule

/* sv/nmea_sentence_framer_checker.sv */
// top level of the nmea sentence framer and checksum checker
// depends on nsfc_pkg, nsfc_front, nsfc_queue and nsfc_back
//
// Usage:
//   Input channel: one received serial byte (rx_byte) per transfer on
//   in_valid / in_stall. Output channel: one result per line feed that
//   closes an open line, on out_valid / out_stall, carrying checksum_ok,
//   sentence_type, line_length and computed_xor.
//   A '$' opens a line, carriage returns are skipped, and a line that
//   reaches LINE_BYTES-2 held bytes is dropped on its next byte.
//   Throughput is one byte per cycle, set by the back end, unless a line
//   feed waits on a stalled result; it updates running xor and tail.
//   A line feed passes front classification and a queue slot before its
//   result is loaded into the result register.
//   A stalled result holds in the output register; the back end keeps
//   taking bytes until another result is due, and the two-entry queue
//   then fills and raises in_stall.
//   Reset (rst_n low, asynchronous) empties the queue, drops any result
//   and closes any open line; no clearing pass is needed afterwards.
module nmea_sentence_framer_checker #(
    parameter int LINE_BYTES = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              checksum_ok,
    output nsfc_pkg::nsfc_type_t sentence_type,
    output logic [6:0]        line_length,
    output logic [7:0]        computed_xor
);
    import nsfc_pkg::*;

    logic       push;
    nsfc_item_t push_item;
    logic       queue_full;
    logic       pop;
    logic       pop_valid;
    nsfc_item_t pop_item;

    // classification front end
    nsfc_front u_front (
        .in_valid   (in_valid),
        .rx_byte    (rx_byte),
        .queue_full (queue_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_item  (push_item)
    );

    // decoupling queue
    nsfc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .full      (queue_full)
    );

    // line framing and checksum back end
    nsfc_back #(
        .LINE_BYTES (LINE_BYTES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (pop_valid),
        .item          (pop_item),
        .item_pop      (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .checksum_ok   (checksum_ok),
        .sentence_type (sentence_type),
        .line_length   (line_length),
        .computed_xor  (computed_xor)
    );

endmodule
